/* design/sfa_pkg.sv */
// ---------------------------------------------------------------------------
// sfa_pkg - shared types and codes of the segregated-fit segment allocator
// Request codes, status codes, cell commands and the token control struct.
// ---------------------------------------------------------------------------
`default_nettype none
package sfa_pkg;

	localparam logic [1:0] FUNC_EXACT = 2'd0;
	localparam logic [1:0] FUNC_BEST  = 2'd1;
	localparam logic [1:0] FUNC_PIECE = 2'd2;
	localparam logic [1:0] FUNC_FREE  = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_OOM  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// results per item, the final failure result included
	localparam int MAX_RESULTS = 32;
	localparam int RES_BITS    = 5;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_CARVE  = 2'd1,
		CMD_TAKE   = 2'd2,
		CMD_INSERT = 2'd3
	} cmd_op_t;

	// control part of the scan token walking down the cell chain
	typedef struct packed {
		logic       valid;
		logic       merge;
		logic       fit_found;
		logic       max_found;
		logic       inv_found;
		logic       changed;
		logic       whole;
		logic [1:0] cnt;
	} tok_ctl_t;

endpackage
`default_nettype wire

/* design/sfa_cell.sv */
// ---------------------------------------------------------------------------
// sfa_cell - one free-segment table entry plus one stage of the scan chain
// Folds its entry into the passing token and registers it for the neighbor.
// ---------------------------------------------------------------------------
`default_nettype none
module sfa_cell
	import sfa_pkg::*;
#(
	parameter int ADDR_BITS    = 16,
	parameter int MAX_SEGMENTS = 32,
	parameter int IDX          = 0
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            clr,
	input  wire logic [ADDR_BITS:0]              pool,
	input  wire cmd_op_t                         cmd_op,
	input  wire logic [$clog2(MAX_SEGMENTS)-1:0] cmd_idx,
	input  wire logic [ADDR_BITS:0]              cmd_lo,
	input  wire logic [ADDR_BITS:0]              cmd_hi,
	input  wire tok_ctl_t                        ti_ctl,
	input  wire logic [ADDR_BITS:0]              ti_size,
	input  wire logic [ADDR_BITS-1:0]            ti_s,
	input  wire logic [ADDR_BITS:0]              ti_e,
	input  wire logic [ADDR_BITS:0]              ti_fit_len,
	input  wire logic [ADDR_BITS-1:0]            ti_fit_start,
	input  wire logic [$clog2(MAX_SEGMENTS)-1:0] ti_fit_idx,
	input  wire logic [ADDR_BITS:0]              ti_max_len,
	input  wire logic [ADDR_BITS-1:0]            ti_max_start,
	input  wire logic [$clog2(MAX_SEGMENTS)-1:0] ti_max_idx,
	input  wire logic [$clog2(MAX_SEGMENTS)-1:0] ti_inv_idx,
	output tok_ctl_t                             to_ctl,
	output logic [ADDR_BITS:0]                   to_size,
	output logic [ADDR_BITS-1:0]                 to_s,
	output logic [ADDR_BITS:0]                   to_e,
	output logic [ADDR_BITS:0]                   to_fit_len,
	output logic [ADDR_BITS-1:0]                 to_fit_start,
	output logic [$clog2(MAX_SEGMENTS)-1:0]      to_fit_idx,
	output logic [ADDR_BITS:0]                   to_max_len,
	output logic [ADDR_BITS-1:0]                 to_max_start,
	output logic [$clog2(MAX_SEGMENTS)-1:0]      to_max_idx,
	output logic [$clog2(MAX_SEGMENTS)-1:0]      to_inv_idx
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [ADDR_BITS-1:0] start_q;
	logic [ADDR_BITS:0]   end_q;
	logic                 valid_q;

	logic [ADDR_BITS:0]   len;
	logic                 hit;
	logic                 post_valid;
	tok_ctl_t             n_ctl;
	logic [ADDR_BITS-1:0] n_s;
	logic [ADDR_BITS:0]   n_e;
	logic [ADDR_BITS:0]   n_fit_len, n_max_len;
	logic [ADDR_BITS-1:0] n_fit_start, n_max_start;
	logic [IW-1:0]        n_fit_idx, n_max_idx, n_inv_idx;

	always_comb begin
		len        = end_q - {1'b0, start_q};
		hit        = ti_ctl.valid && ti_ctl.merge && valid_q &&
		             ({1'b0, start_q} <= ti_e) && (end_q >= {1'b0, ti_s});
		post_valid = valid_q && !hit;
		n_ctl       = ti_ctl;
		n_s         = ti_s;
		n_e         = ti_e;
		n_fit_len   = ti_fit_len;
		n_fit_start = ti_fit_start;
		n_fit_idx   = ti_fit_idx;
		n_max_len   = ti_max_len;
		n_max_start = ti_max_start;
		n_max_idx   = ti_max_idx;
		n_inv_idx   = ti_inv_idx;
		if (hit) begin
			if (start_q < ti_s) n_s = start_q;
			if (end_q > ti_e) n_e = end_q;
			n_ctl.changed = 1'b1;
		end
		if (!ti_ctl.merge && valid_q) begin
			// smallest fitting segment, lowest address on a tie
			if (len >= ti_size && (!ti_ctl.fit_found || len < ti_fit_len ||
			    (len == ti_fit_len && start_q < ti_fit_start))) begin
				n_ctl.fit_found = 1'b1;
				n_fit_len       = len;
				n_fit_start     = start_q;
				n_fit_idx       = MY_IDX;
			end
			// largest segment overall, lowest address on a tie
			if (!ti_ctl.max_found || len > ti_max_len ||
			    (len == ti_max_len && start_q < ti_max_start)) begin
				n_ctl.max_found = 1'b1;
				n_max_len       = len;
				n_max_start     = start_q;
				n_max_idx       = MY_IDX;
			end
		end
		if (post_valid) begin
			n_ctl.cnt = (ti_ctl.cnt == 2'd0) ? 2'd1 : 2'd2;
			if (start_q == '0 && end_q == pool) n_ctl.whole = 1'b1;
		end else if (!ti_ctl.inv_found) begin
			n_ctl.inv_found = 1'b1;
			n_inv_idx       = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_ctl <= '0;
		end else begin
			to_ctl <= n_ctl;
		end
	end

	always_ff @(posedge clk) begin
		to_size      <= ti_size;
		to_s         <= n_s;
		to_e         <= n_e;
		to_fit_len   <= n_fit_len;
		to_fit_start <= n_fit_start;
		to_fit_idx   <= n_fit_idx;
		to_max_len   <= n_max_len;
		to_max_start <= n_max_start;
		to_max_idx   <= n_max_idx;
		to_inv_idx   <= n_inv_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= (IDX == 0);
			start_q <= '0;
			end_q   <= (ADDR_BITS+1)'(1) << ADDR_BITS;
		end else if (clr) begin
			valid_q <= (IDX == 0);
			start_q <= '0;
			end_q   <= pool;
		end else if (hit) begin
			valid_q <= 1'b0;
		end else if (cmd_idx == MY_IDX) begin
			case (cmd_op)
				CMD_CARVE: begin
					start_q <= start_q + cmd_lo[ADDR_BITS-1:0];
				end
				CMD_TAKE: begin
					valid_q <= 1'b0;
				end
				CMD_INSERT: begin
					valid_q <= 1'b1;
					start_q <= cmd_lo[ADDR_BITS-1:0];
					end_q   <= cmd_hi;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/segregated_fit_segment_allocator.sv */
// ---------------------------------------------------------------------------
// segregated_fit_segment_allocator - free-segment allocator with coalescing
// Table of free segments kept in a chain of cells scanned by a walking token.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries func, req_size and free_offset.
//   Output channel (out_valid/out_stall) carries seg_offset, seg_length,
//   status, last and all_free; every item yields one result, piecewise
//   allocation up to MAX_RESULTS, the final one marked by last.
//   pool_size is written with cfg_we while idle; the table is cleared to one
//   free segment covering the whole pool by the registered clear that follows
//   the write (value clamped to 1..2^A).
// Operation:
//   A table scan is a launch, the token walk down the chain and a decide
//   step; the token moves one cell a cycle. Alloc: a search scan, a commit
//   and a report scan before the first result. The report scan doubles as
//   the next search, so each further piece needs an emit, a decide, a
//   commit and one more report scan.
//   Free: one merge scan per growth step plus one clean scan, plus report.
//   One item is worked at a time; in_stall is high while busy.
// Reset: the pool is 2^ADDR_BITS units, one free segment at address zero.
// A stalled receiver holds the result register; work resumes once taken.
// ---------------------------------------------------------------------------
`default_nettype none
module segregated_fit_segment_allocator
	import sfa_pkg::*;
#(
	parameter int ADDR_BITS    = 16,
	parameter int MAX_SEGMENTS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [ADDR_BITS:0]   pool_size,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           func,
	input  wire logic [ADDR_BITS:0]   req_size,
	input  wire logic [ADDR_BITS-1:0] free_offset,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [ADDR_BITS-1:0]      seg_offset,
	output logic [ADDR_BITS:0]        seg_length,
	output logic [1:0]                status,
	output logic                      last,
	output logic                      all_free
);

	localparam int A  = ADDR_BITS;
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int N  = MAX_SEGMENTS;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LAUNCH = 6'b000010,
		ST_WAIT   = 6'b000100,
		ST_DECIDE = 6'b001000,
		ST_COMMIT = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_MERGE  = 2'd1,
		PH_REPORT = 2'd2
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [1:0]        func_q;
	logic [A:0]        rem_q;
	logic [A-1:0]      s_q;
	logic [A:0]        e_q;
	logic [RES_BITS-1:0] n_q;
	logic [A:0]        pool_q;
	logic              clr_q;
	logic [A-1:0]      r_off_q;
	logic [A:0]        r_len_q;
	logic [1:0]        r_stat_q;
	logic              r_last_q;
	cmd_op_t           cmd_op_q;
	logic [IW-1:0]     cmd_idx_q;
	logic [A:0]        cmd_lo_q, cmd_hi_q;
	tok_ctl_t          sc_ctl_q;
	logic [A:0]        sc_fit_len_q, sc_max_len_q;
	logic [A-1:0]      sc_fit_start_q, sc_max_start_q;
	logic [IW-1:0]     sc_fit_idx_q, sc_max_idx_q, sc_inv_idx_q;

	// token chain, position 0 is injected here
	tok_ctl_t          tk_ctl       [0:N];
	logic [A:0]        tk_size      [0:N];
	logic [A-1:0]      tk_s         [0:N];
	logic [A:0]        tk_e         [0:N];
	logic [A:0]        tk_fit_len   [0:N];
	logic [A-1:0]      tk_fit_start [0:N];
	logic [IW-1:0]     tk_fit_idx   [0:N];
	logic [A:0]        tk_max_len   [0:N];
	logic [A-1:0]      tk_max_start [0:N];
	logic [IW-1:0]     tk_max_idx   [0:N];
	logic [IW-1:0]     tk_inv_idx   [0:N];

	cmd_op_t           cmd_op;
	logic              in_acc;
	logic [A+1:0]      free_end;
	logic [A:0]        pool_clamped;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign free_end = {2'b00, free_offset} + {1'b0, req_size};
	assign cmd_op   = (state_q == ST_COMMIT) ? cmd_op_q : CMD_NONE;

	always_comb begin
		pool_clamped = pool_size;
		if (pool_size == '0) pool_clamped = (A+1)'(1);
		if (pool_size[A] && (|pool_size[A-1:0])) pool_clamped = (A+1)'(1) << A;
	end

	always_comb begin
		tk_ctl[0]       = '0;
		tk_ctl[0].valid = (state_q == ST_LAUNCH);
		tk_ctl[0].merge = (phase_q == PH_MERGE);
		tk_size[0]      = rem_q;
		tk_s[0]         = s_q;
		tk_e[0]         = e_q;
		tk_fit_len[0]   = '0;
		tk_fit_start[0] = '0;
		tk_fit_idx[0]   = '0;
		tk_max_len[0]   = '0;
		tk_max_start[0] = '0;
		tk_max_idx[0]   = '0;
		tk_inv_idx[0]   = '0;
	end

	// cells clear from the stored pool size, through the registered clear clr_q
	for (genvar g = 0; g < N; g++) begin : g_cell
		sfa_cell #(
			.ADDR_BITS   (A),
			.MAX_SEGMENTS(N),
			.IDX         (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.clr         (clr_q),
			.pool        (pool_q),
			.cmd_op      (cmd_op),
			.cmd_idx     (cmd_idx_q),
			.cmd_lo      (cmd_lo_q),
			.cmd_hi      (cmd_hi_q),
			.ti_ctl      (tk_ctl[g]),
			.ti_size     (tk_size[g]),
			.ti_s        (tk_s[g]),
			.ti_e        (tk_e[g]),
			.ti_fit_len  (tk_fit_len[g]),
			.ti_fit_start(tk_fit_start[g]),
			.ti_fit_idx  (tk_fit_idx[g]),
			.ti_max_len  (tk_max_len[g]),
			.ti_max_start(tk_max_start[g]),
			.ti_max_idx  (tk_max_idx[g]),
			.ti_inv_idx  (tk_inv_idx[g]),
			.to_ctl      (tk_ctl[g+1]),
			.to_size     (tk_size[g+1]),
			.to_s        (tk_s[g+1]),
			.to_e        (tk_e[g+1]),
			.to_fit_len  (tk_fit_len[g+1]),
			.to_fit_start(tk_fit_start[g+1]),
			.to_fit_idx  (tk_fit_idx[g+1]),
			.to_max_len  (tk_max_len[g+1]),
			.to_max_start(tk_max_start[g+1]),
			.to_max_idx  (tk_max_idx[g+1]),
			.to_inv_idx  (tk_inv_idx[g+1])
		);
	end

	// chain tail results; tk_size at the tail is the launched size, unused here
	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && tk_ctl[N].valid) begin
			sc_fit_len_q   <= tk_fit_len[N];
			sc_fit_start_q <= tk_fit_start[N];
			sc_fit_idx_q   <= tk_fit_idx[N];
			sc_max_len_q   <= tk_max_len[N];
			sc_max_start_q <= tk_max_start[N];
			sc_max_idx_q   <= tk_max_idx[N];
			sc_inv_idx_q   <= tk_inv_idx[N];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= (A+1)'(1) << A;
			clr_q  <= 1'b0;
		end else begin
			clr_q <= cfg_we;
			if (cfg_we) pool_q <= pool_clamped;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_SEARCH;
			out_valid <= 1'b0;
			cmd_op_q  <= CMD_NONE;
			sc_ctl_q  <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_EMIT) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						func_q   <= func;
						rem_q    <= req_size;
						n_q      <= '0;
						r_off_q  <= '0;
						r_len_q  <= '0;
						r_stat_q <= STAT_OK;
						r_last_q <= 1'b1;
						state_q  <= ST_LAUNCH;
						if (func == FUNC_FREE) begin
							s_q <= free_offset;
							e_q <= free_end[A:0];
							if (req_size == '0 || free_end > {1'b0, pool_q}) begin
								phase_q <= PH_REPORT;
							end else begin
								phase_q <= PH_MERGE;
							end
						end else if (req_size == '0) begin
							phase_q <= PH_REPORT;
						end else begin
							phase_q <= PH_SEARCH;
						end
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (tk_ctl[N].valid) begin
						sc_ctl_q <= tk_ctl[N];
						s_q      <= tk_s[N];
						e_q      <= tk_e[N];
						state_q  <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					case (phase_q)
						PH_MERGE: begin
							if (sc_ctl_q.changed) begin
								state_q <= ST_LAUNCH;
							end else begin
								phase_q <= PH_REPORT;
								if (sc_ctl_q.inv_found) begin
									cmd_op_q  <= CMD_INSERT;
									cmd_idx_q <= sc_inv_idx_q;
									cmd_lo_q  <= {1'b0, s_q};
									cmd_hi_q  <= e_q;
									state_q   <= ST_COMMIT;
								end else begin
									r_stat_q <= STAT_FULL;
									state_q  <= ST_LAUNCH;
								end
							end
						end
						PH_SEARCH: begin
							if (func_q == FUNC_PIECE &&
							    n_q == RES_BITS'(MAX_RESULTS - 1)) begin
								r_off_q  <= '0;
								r_len_q  <= '0;
								r_stat_q <= STAT_OOM;
								r_last_q <= 1'b1;
								state_q  <= ST_EMIT;
							end else if (sc_ctl_q.fit_found) begin
								// carve the request from the low end
								r_off_q   <= sc_fit_start_q;
								r_len_q   <= rem_q;
								r_stat_q  <= STAT_OK;
								r_last_q  <= 1'b1;
								rem_q     <= '0;
								cmd_op_q  <= (sc_fit_len_q == rem_q) ? CMD_TAKE : CMD_CARVE;
								cmd_idx_q <= sc_fit_idx_q;
								cmd_lo_q  <= rem_q;
								phase_q   <= PH_REPORT;
								state_q   <= ST_COMMIT;
							end else if (func_q != FUNC_EXACT && sc_ctl_q.max_found) begin
								// nothing fits: take the largest segment whole
								r_off_q   <= sc_max_start_q;
								r_len_q   <= sc_max_len_q;
								r_stat_q  <= STAT_OK;
								r_last_q  <= (func_q == FUNC_BEST) ||
								             (rem_q == sc_max_len_q);
								rem_q     <= rem_q - sc_max_len_q;
								cmd_op_q  <= CMD_TAKE;
								cmd_idx_q <= sc_max_idx_q;
								phase_q   <= PH_REPORT;
								state_q   <= ST_COMMIT;
							end else begin
								r_off_q  <= '0;
								r_len_q  <= '0;
								r_stat_q <= STAT_OOM;
								r_last_q <= 1'b1;
								state_q  <= ST_EMIT;
							end
						end
						default: begin
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_COMMIT: begin
					state_q <= ST_LAUNCH;
				end
				ST_EMIT: begin
					if (!out_valid || !out_stall) begin
						out_valid  <= 1'b1;
						seg_offset <= r_off_q;
						seg_length <= r_len_q;
						status     <= r_stat_q;
						last       <= r_last_q;
						all_free   <= (sc_ctl_q.cnt == 2'd1) && sc_ctl_q.whole;
						if (r_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							n_q     <= n_q + 1'b1;
							phase_q <= PH_SEARCH;
							state_q <= ST_DECIDE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a scan token only leaves the chain while the sequencer waits for it
	a_tok_wait: assert property (@(posedge clk) disable iff (!arst_n)
		tk_ctl[N].valid |-> state_q == ST_WAIT)
		else $error("scan token left chain outside wait");

	// a table-full answer ends its item
	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> last)
		else $error("table full result not last");

	// a granted length always comes with ok status
	a_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seg_length != '0 |-> status == STAT_OK)
		else $error("nonzero length with error status");

	// commands reach the cells for one cycle only
	a_cmd_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMMIT |=> state_q == ST_LAUNCH)
		else $error("commit lasted more than one cycle");

endmodule
`default_nettype wire

/* dv/sfa_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sfa_checker - result checker of the segregated-fit segment allocator
// Watches both channels and the pool size write. It keeps its own free table,
// works out the results of every accepted item and compares them in order.
// ---------------------------------------------------------------------------
module sfa_checker
	import sfa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] pool_size,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [16:0] req_size,
	input  wire logic [15:0] free_offset,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [15:0] seg_offset,
	input  wire logic [16:0] seg_length,
	input  wire logic [1:0]  status,
	input  wire logic        last,
	input  wire logic        all_free,
	output int               errors,
	output int               pending,
	output int               n_items,
	output int               n_results,
	output int               n_oom,
	output int               n_full
);

	localparam int SEGS    = 32;
	localparam int CLASSES = 17;

	typedef struct {
		int   off;
		int   len;
		logic [1:0] st;
		bit   fin;
		bit   whole;
	} grant_t;

	int     seg_lo[SEGS];
	int     seg_hi[SEGS];
	bit     seg_ok[SEGS];
	int     pool;
	grant_t grants_due[$];

	function automatic void wipe_table();
		for (int i = 0; i < SEGS; i++) begin
			seg_lo[i] = 0;
			seg_hi[i] = 0;
			seg_ok[i] = 0;
		end
		seg_hi[0] = pool;
		seg_ok[0] = 1;
	endfunction

	function automatic int size_cls(int n);
		int c;
		c = 0;
		while (n >= 2) begin
			n = n >> 1;
			c++;
		end
		return (c > CLASSES - 1) ? CLASSES - 1 : c;
	endfunction

	function automatic bit pool_whole();
		int cnt;
		bit hit;
		cnt = 0;
		hit = 0;
		for (int i = 0; i < SEGS; i++)
			if (seg_ok[i]) begin
				cnt++;
				if (seg_lo[i] == 0 && seg_hi[i] == pool) hit = 1;
			end
		return cnt == 1 && hit;
	endfunction

	function automatic void drop_seg(int i);
		seg_ok[i] = 0;
		seg_lo[i] = 0;
		seg_hi[i] = 0;
	endfunction

	function automatic void post(int off, int len, logic [1:0] st, bit fin);
		grant_t g;
		g.off   = off & 16'hFFFF;
		g.len   = len & 17'h1FFFF;
		g.st    = st;
		g.fin   = fin;
		g.whole = pool_whole();
		grants_due.push_back(g);
	endfunction

	// smallest fitting segment, searched class by class upward
	function automatic bit carve_fit(int sz, output int off);
		int pick, ln, pl;
		off = 0;
		for (int c = size_cls(sz); c < CLASSES; c++) begin
			pick = -1;
			for (int i = 0; i < SEGS; i++) begin
				if (!seg_ok[i]) continue;
				ln = seg_hi[i] - seg_lo[i];
				if (size_cls(ln) != c || ln < sz) continue;
				if (pick < 0) pick = i;
				else begin
					pl = seg_hi[pick] - seg_lo[pick];
					if (ln < pl || (ln == pl && seg_lo[i] < seg_lo[pick])) pick = i;
				end
			end
			if (pick >= 0) begin
				off = seg_lo[pick];
				if (seg_hi[pick] - seg_lo[pick] == sz) drop_seg(pick);
				else seg_lo[pick] += sz;
				return 1;
			end
		end
		return 0;
	endfunction

	// smallest fitting segment first, else the largest segment of the highest class at or below
	function automatic bit take_best(int sz, output int off, output int len);
		int pick, l, pl;
		len = 0;
		if (carve_fit(sz, off)) begin
			len = sz;
			return 1;
		end
		for (int c = size_cls(sz); c >= 0; c--) begin
			pick = -1;
			for (int i = 0; i < SEGS; i++) begin
				if (!seg_ok[i]) continue;
				l = seg_hi[i] - seg_lo[i];
				if (size_cls(l) != c) continue;
				if (pick < 0) pick = i;
				else begin
					pl = seg_hi[pick] - seg_lo[pick];
					if (l > pl || (l == pl && seg_lo[i] < seg_lo[pick])) pick = i;
				end
			end
			if (pick >= 0) begin
				off = seg_lo[pick];
				len = seg_hi[pick] - seg_lo[pick];
				drop_seg(pick);
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic logic [1:0] give_back(int off, int len);
		int s, e;
		bit grew;
		s = off;
		e = off + len;
		grew = 1;
		if (len == 0 || e > pool) return STAT_OK;
		while (grew) begin
			grew = 0;
			for (int i = 0; i < SEGS; i++)
				if (seg_ok[i] && seg_lo[i] <= e && seg_hi[i] >= s) begin
					if (seg_lo[i] < s) s = seg_lo[i];
					if (seg_hi[i] > e) e = seg_hi[i];
					drop_seg(i);
					grew = 1;
				end
		end
		for (int i = 0; i < SEGS; i++)
			if (!seg_ok[i]) begin
				seg_ok[i] = 1;
				seg_lo[i] = s;
				seg_hi[i] = e;
				return STAT_OK;
			end
		return STAT_FULL;
	endfunction

	function automatic void predict(logic [1:0] f, int sz, int foff);
		int off, len, left, n;
		if (f == FUNC_FREE) begin
			post(0, 0, give_back(foff, sz), 1);
			return;
		end
		if (sz == 0) begin
			post(0, 0, STAT_OK, 1);
			return;
		end
		if (f == FUNC_EXACT) begin
			if (carve_fit(sz, off)) post(off, sz, STAT_OK, 1);
			else post(0, 0, STAT_OOM, 1);
			return;
		end
		if (f == FUNC_BEST) begin
			if (take_best(sz, off, len)) post(off, len, STAT_OK, 1);
			else post(0, 0, STAT_OOM, 1);
			return;
		end
		left = sz;
		n = 0;
		while (left > 0) begin
			if (n == MAX_RESULTS - 1 || !take_best(left, off, len)) begin
				post(0, 0, STAT_OOM, 1);
				return;
			end
			left -= len;
			post(off, len, STAT_OK, left == 0);
			n++;
		end
	endfunction

	function automatic void cmp(string what, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		if (!arst_n) begin
			pool = 65536;
			wipe_table();
			grants_due.delete();
			errors = 0;
			n_items = 0;
			n_results = 0;
			n_oom = 0;
			n_full = 0;
		end else begin
			// results first: a result never belongs to an item taken at this edge
			if (out_valid && !out_stall) begin
				n_results++;
				if (status == STAT_OOM) n_oom++;
				if (status == STAT_FULL) n_full++;
				if (grants_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result offset %0d length %0d status %0d",
						$time, seg_offset, seg_length, status);
				end else begin
					g = grants_due.pop_front();
					cmp("seg_offset", g.off, int'(seg_offset));
					cmp("seg_length", g.len, int'(seg_length));
					cmp("status", int'(g.st), int'(status));
					cmp("last", int'(g.fin), int'(last));
					cmp("all_free", int'(g.whole), int'(all_free));
				end
			end
			if (cfg_we) begin
				pool = int'(pool_size);
				if (pool < 1) pool = 1;
				if (pool > 65536) pool = 65536;
				wipe_table();
			end
			if (in_valid && !in_stall) begin
				n_items++;
				predict(func, int'(req_size), int'(free_offset));
			end
		end
		pending = grants_due.size();
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - testbench of the segregated-fit segment allocator
// Directed corner items, then random phases over several pool sizes with
// frees drawn from segments granted earlier; a checker compares all results.
// ---------------------------------------------------------------------------
module tb;
	import sfa_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [16:0] pool_size;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [16:0] req_size;
	logic [15:0] free_offset;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] seg_offset;
	logic [16:0] seg_length;
	logic [1:0]  status;
	logic        last;
	logic        all_free;

	int errors, pending, n_items, n_results, n_oom, n_full;

	// segments handed out so far; frees are mostly drawn from here
	typedef struct {
		int off;
		int len;
	} held_t;
	held_t held[$];

	int cur_pool;
	bit calm;        // no gaps on either side while set
	int hold_asks;   // bumped by the sender to ask for a long receiver hold-off
	int hold_done;

	segregated_fit_segment_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .pool_size(pool_size),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .req_size(req_size), .free_offset(free_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.seg_offset(seg_offset), .seg_length(seg_length),
		.status(status), .last(last), .all_free(all_free)
	);

	sfa_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .pool_size(pool_size),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .req_size(req_size), .free_offset(free_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.seg_offset(seg_offset), .seg_length(seg_length),
		.status(status), .last(last), .all_free(all_free),
		.errors(errors), .pending(pending), .n_items(n_items),
		.n_results(n_results), .n_oom(n_oom), .n_full(n_full)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// hard stop in case the block hangs
	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// track what was granted, so later frees are well formed
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall && status == STAT_OK && seg_length != 0)
			held.push_back('{int'(seg_offset), int'(seg_length)});

	// receiver: random stalls, plus a long counted hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_done) begin
				hold_done++;
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
				n = gap_len();
				if (n > 0) begin
					@(negedge clk);
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
			end
		end
	end

	// offer one item at a falling edge and hold it until taken
	task automatic send(logic [1:0] f, int sz, int off);
		int n;
		func        <= f;
		req_size    <= sz[16:0];
		free_offset <= off[15:0];
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// stop offering and let every expected result come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic set_pool(int v);
		drain();
		cfg_we    <= 1'b1;
		pool_size <= v[16:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_pool = (v & 17'h1FFFF) < 1 ? 1 : ((v & 17'h1FFFF) > 65536 ? 65536 : v & 17'h1FFFF);
		held.delete();
		@(negedge clk);
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 15) return $urandom_range(1, cur_pool);
		if (r < 20) return $urandom & 17'h1FFFF;
		return $urandom_range(1, cur_pool / 8 + 1);
	endfunction

	// one random item: allocations, well-formed frees, and some noise
	task automatic random_item();
		int r, k, s, l;
		held_t h;
		r = $urandom_range(0, 99);
		if (r < 28) send(FUNC_EXACT, pick_size(), $urandom);
		else if (r < 43) send(FUNC_BEST, pick_size(), $urandom);
		else if (r < 53) send(FUNC_PIECE, pick_size(), $urandom);
		else if (r < 88 && held.size() != 0) begin
			k = $urandom_range(0, held.size() - 1);
			h = held[k];
			held.delete(k);
			if (h.len > 1 && $urandom_range(0, 2) == 0) begin
				// give back only part of the segment
				s = h.off + $urandom_range(0, h.len - 1);
				l = $urandom_range(1, h.off + h.len - s);
				send(FUNC_FREE, l, s);
			end else
				send(FUNC_FREE, h.len, h.off);
		end else
			send(2'($urandom_range(0, 3)), $urandom & 17'h1FFFF, $urandom & 16'hFFFF);
	endtask

	initial begin
		int pools[7];
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		pool_size   = '0;
		in_valid    = 1'b0;
		func        = FUNC_EXACT;
		req_size    = '0;
		free_offset = '0;
		hold_asks   = 0;
		calm        = 0;
		cur_pool    = 65536;
		pools       = '{1, 0, 131071, 48, 4096, 300, 65536};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners on the full pool
		send(FUNC_EXACT, 65536, 0);        // whole pool in one grant
		send(FUNC_EXACT, 1, 0);            // nothing left
		send(FUNC_BEST, 5, 0);
		send(FUNC_PIECE, 3, 0);
		send(FUNC_FREE, 65536, 0);         // back to one free segment
		send(FUNC_EXACT, 0, 16'hFFFF);     // zero-size requests
		send(FUNC_BEST, 0, 0);
		send(FUNC_PIECE, 0, 0);
		send(FUNC_FREE, 0, 100);           // zero-length free is ignored
		send(FUNC_FREE, 2, 65535);         // reaches past the pool
		send(FUNC_FREE, 1, 65535);         // overlaps the free segment
		send(FUNC_EXACT, 100, 0);
		send(FUNC_EXACT, 1000, 0);
		send(FUNC_EXACT, 100, 0);
		send(FUNC_FREE, 1000, 100);        // hole between two grants
		send(FUNC_BEST, 131071, 0);        // more than the pool: fallback
		send(FUNC_BEST, 600, 0);           // fits in the freed hole
		send(FUNC_FREE, 50, 40);           // partial free inside the first grant
		send(FUNC_PIECE, 65536, 0);        // piecewise up to the shortfall
		send(FUNC_FREE, 65536, 0);
		send(FUNC_EXACT, 3, 0);
		send(FUNC_EXACT, 3, 0);
		send(FUNC_FREE, 3, 0);             // first hole: an exact fit
		send(FUNC_EXACT, 3, 0);

		// receiver holds off while the sender keeps offering
		hold_asks++;
		repeat (30) random_item();
		// sender pauses until everything has come back
		drain();

		// piecewise over many small fragments, until they run out
		set_pool(4096);
		for (int i = 0; i < 40; i++) send(FUNC_EXACT, 8, 0);
		for (int i = 0; i < 40; i += 2) send(FUNC_FREE, 8, i * 8);
		send(FUNC_PIECE, 4096, 0);

		// fragment the table until a free finds no room
		set_pool(200);
		calm = 1;
		for (int i = 0; i < 70; i++) send(FUNC_EXACT, 1, 0);
		for (int i = 0; i < 35; i++) send(FUNC_FREE, 1, 2 * i);
		calm = 0;
		held.delete();

		foreach (pools[p]) begin
			set_pool(pools[p]);
			calm = (p == 3);
			repeat (23) random_item();
		end
		drain();

		$display("Covered %0d items and %0d results: %0d out of memory, %0d table full,",
			n_items, n_results, n_oom, n_full);
		$display("over nine pool sizes with partial, overlapping and bad frees.");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
